// ===== design/tqm_pkg.sv =====
// tqm_pkg: shared types, constants and helpers for the traffic quota meter
// no dependencies; every other file refers to it by scoped names
package tqm_pkg;

    // width of the cumulative byte counters that deltas are taken over
    localparam int COUNTER_WIDTH = 64;
    // width of the usage counters and limits
    localparam int COUNT_W       = 64;
    localparam int DAY_W         = 5;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 3;

    typedef logic [COUNT_W-1:0]       t_count;
    typedef logic [COUNTER_WIDTH-1:0] t_delta;
    typedef logic [DAY_W-1:0]         t_day;
    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // limit modes
    localparam t_mode MODE_UL      = 2'd0;
    localparam t_mode MODE_ULDL    = 2'd1;
    localparam t_mode MODE_MAXULDL = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx CFG_MODE_SEL       = 3'd0;
    localparam t_cfg_idx CFG_UPLOAD_LIMIT   = 3'd1;
    localparam t_cfg_idx CFG_DOWNLOAD_LIMIT = 3'd2;
    localparam t_cfg_idx CFG_TOTAL_LIMIT    = 3'd3;
    localparam t_cfg_idx CFG_RESTART_DAY    = 3'd4;

    // configuration register set
    typedef struct packed {
        t_mode  mode_sel;
        t_count upload_limit;
        t_count download_limit;
        t_count total_limit;
        t_day   restart_day;
    } t_cfg;

    // one sample after the delta stage
    typedef struct packed {
        logic   first;
        t_delta dtx;
        t_delta drx;
        t_day   day;
        t_day   mdays;
    } t_sample;

    // saturating add of two usage values
    function automatic t_count sat_add(input t_count a, input t_count b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

endpackage

// ===== design/tqm_cfg.sv =====
// tqm_cfg: configuration register file of the traffic quota meter
// depends on tqm_pkg
module tqm_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  tqm_pkg::t_cfg_idx i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output tqm_pkg::t_cfg     o_cfg
);

    tqm_pkg::t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_sel       <= tqm_pkg::MODE_UL;
            r_cfg.upload_limit   <= '1;
            r_cfg.download_limit <= '1;
            r_cfg.total_limit    <= '1;
            r_cfg.restart_day    <= tqm_pkg::t_day'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tqm_pkg::CFG_MODE_SEL:       r_cfg.mode_sel       <= i_cfg_data[1:0];
                tqm_pkg::CFG_UPLOAD_LIMIT:   r_cfg.upload_limit   <= i_cfg_data;
                tqm_pkg::CFG_DOWNLOAD_LIMIT: r_cfg.download_limit <= i_cfg_data;
                tqm_pkg::CFG_TOTAL_LIMIT:    r_cfg.total_limit    <= i_cfg_data;
                tqm_pkg::CFG_RESTART_DAY:    r_cfg.restart_day    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== design/tqm_delta.sv =====
// tqm_delta: input stage; registers each request and the wrapping counter deltas
// depends on tqm_pkg
module tqm_delta (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [63:0]      i_tx_total,
    input  logic [63:0]      i_rx_total,
    input  logic [4:0]       i_day_of_month,
    input  logic [4:0]       i_days_in_month,
    input  logic             i_advance,
    output logic             o_valid,
    output tqm_pkg::t_sample o_sample
);

    logic             r_valid;
    logic             r_primed;
    tqm_pkg::t_delta  r_prev_tx;
    tqm_pkg::t_delta  r_prev_rx;
    tqm_pkg::t_sample r_sample;
    logic             accept;

    // stage may load when empty or when its request moves on
    assign o_in_ready = !r_valid || i_advance;
    assign accept     = i_in_valid && o_in_ready;
    assign o_valid    = r_valid;
    assign o_sample   = r_sample;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_primed <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_valid <= i_in_valid;
            end
            if (accept) begin
                r_primed <= 1'b1;
            end
        end
    end

    // baselines are always the previous request's counters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample.first <= !r_primed;
            r_sample.dtx   <= i_tx_total[tqm_pkg::COUNTER_WIDTH-1:0] - r_prev_tx;
            r_sample.drx   <= i_rx_total[tqm_pkg::COUNTER_WIDTH-1:0] - r_prev_rx;
            r_sample.day   <= i_day_of_month;
            r_sample.mdays <= i_days_in_month;
            r_prev_tx      <= i_tx_total[tqm_pkg::COUNTER_WIDTH-1:0];
            r_prev_rx      <= i_rx_total[tqm_pkg::COUNTER_WIDTH-1:0];
        end
    end

endmodule

// ===== design/tqm_core.sv =====
// tqm_core: day handling, saturating usage accumulation, limit check, result register
// depends on tqm_pkg
module tqm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tqm_pkg::t_sample i_sample,
    input  tqm_pkg::t_cfg    i_cfg,
    output logic             o_load,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_throttle_active,
    output logic             o_throttle_started,
    output logic             o_throttle_ended,
    output logic             o_period_reset,
    output logic [63:0]      o_upload_used,
    output logic [63:0]      o_download_used,
    output logic [63:0]      o_total_used
);

    logic            r_out_valid;
    logic            r_started;
    logic            r_ended;
    logic            r_period_reset;
    tqm_pkg::t_count r_upload;
    tqm_pkg::t_count r_download;
    tqm_pkg::t_count r_combined;
    tqm_pkg::t_day   r_prev_day;
    logic            r_cleared;
    logic            r_throttle;

    tqm_pkg::t_count n_upload;
    tqm_pkg::t_count n_download;
    tqm_pkg::t_count n_combined;
    tqm_pkg::t_day   n_prev_day;
    logic            n_cleared;
    logic            n_throttle;
    logic            n_started;
    logic            n_ended;
    logic            n_period_reset;

    logic            process;
    logic            over;
    tqm_pkg::t_count dtx_ext;
    tqm_pkg::t_count drx_ext;
    tqm_pkg::t_count comb_mid;

    // result register frees up when empty or taken
    assign o_load      = !r_out_valid || i_out_ready;
    assign process     = i_valid && o_load;
    assign o_out_valid = r_out_valid;

    assign dtx_ext = tqm_pkg::t_count'(i_sample.dtx);
    assign drx_ext = tqm_pkg::t_count'(i_sample.drx);

    // next state for one request
    always_comb begin
        n_upload       = r_upload;
        n_download     = r_download;
        n_combined     = r_combined;
        n_prev_day     = r_prev_day;
        n_cleared      = r_cleared;
        n_throttle     = r_throttle;
        n_started      = 1'b0;
        n_ended        = 1'b0;
        n_period_reset = 1'b0;
        over           = 1'b0;
        comb_mid       = '0;
        if (i_sample.first) begin
            n_prev_day = i_sample.day;
        end else begin
            // day change: first after a reset, or reset day (month end if earlier)
            if (i_sample.day != r_prev_day) begin
                n_prev_day = i_sample.day;
                if (r_cleared) begin
                    n_cleared = 1'b0;
                    if (r_throttle) begin
                        n_throttle = 1'b0;
                        n_ended    = 1'b1;
                    end
                end else if ((i_sample.day == i_sample.mdays &&
                              i_sample.day < i_cfg.restart_day) ||
                             i_sample.day == i_cfg.restart_day) begin
                    n_upload       = '0;
                    n_download     = '0;
                    n_combined     = '0;
                    n_cleared      = 1'b1;
                    n_period_reset = 1'b1;
                    if (r_throttle) begin
                        n_throttle = 1'b0;
                        n_ended    = 1'b1;
                    end
                end
            end
            // accumulate and check against the quota of the mode
            case (i_cfg.mode_sel)
                tqm_pkg::MODE_UL: begin
                    n_upload = tqm_pkg::sat_add(n_upload, dtx_ext);
                    over     = n_upload >= i_cfg.upload_limit;
                end
                tqm_pkg::MODE_ULDL: begin
                    comb_mid   = tqm_pkg::sat_add(n_combined, dtx_ext);
                    n_combined = tqm_pkg::sat_add(comb_mid, drx_ext);
                    over       = n_combined >= i_cfg.total_limit;
                end
                tqm_pkg::MODE_MAXULDL: begin
                    n_upload   = tqm_pkg::sat_add(n_upload, dtx_ext);
                    n_download = tqm_pkg::sat_add(n_download, drx_ext);
                    over       = n_upload >= i_cfg.upload_limit ||
                                 n_download >= i_cfg.download_limit;
                end
                default: over = 1'b0;
            endcase
            if (!n_throttle && over) begin
                n_throttle = 1'b1;
                n_started  = 1'b1;
            end
        end
    end

    // meter state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_upload    <= '0;
            r_download  <= '0;
            r_combined  <= '0;
            r_prev_day  <= '0;
            r_cleared   <= 1'b0;
            r_throttle  <= 1'b0;
        end else begin
            if (o_load) begin
                r_out_valid <= i_valid;
            end
            if (process) begin
                r_upload   <= n_upload;
                r_download <= n_download;
                r_combined <= n_combined;
                r_prev_day <= n_prev_day;
                r_cleared  <= n_cleared;
                r_throttle <= n_throttle;
            end
        end
    end

    // per-request event flags
    always_ff @(posedge i_clk) begin
        if (process) begin
            r_started      <= n_started;
            r_ended        <= n_ended;
            r_period_reset <= n_period_reset;
        end
    end

    // counters only move on a new request, so they double as the result
    assign o_throttle_active  = r_throttle;
    assign o_throttle_started = r_started;
    assign o_throttle_ended   = r_ended;
    assign o_period_reset     = r_period_reset;
    assign o_upload_used      = r_upload;
    assign o_download_used    = r_download;
    assign o_total_used       = r_combined;

endmodule

// ===== design/traffic_quota_meter.sv =====
// traffic_quota_meter: top level of the monthly byte quota meter
// depends on tqm_pkg, tqm_cfg, tqm_delta and tqm_core
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one periodic sample: the
//   cumulative tx and rx byte counters, the day of month and the month length.
//   Output channel (o_out_valid / i_out_ready) returns one result per request:
//   throttle state and events, plus the three usage counters.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
//   writes limit mode, the three limits and the reset day; always ready, and
//   meant to be written while no request is in flight.
// Timing:
//   From input acceptance to result valid, a delta stage registers the request
//   and the wrapping counter deltas, then the quota stage updates the meter
//   state and registers the result. Throughput is one request per cycle
//   while results are taken; the state loop closes within the quota stage,
//   so consecutive requests follow without gaps.
// Reset and stalls:
//   Synchronous active-low reset clears all meter state and sets the limits to
//   all ones; the first sample afterwards only records baselines.
//   When the receiver stalls, the result holds and the delta stage takes one
//   further request only if it was empty; then o_in_ready drops.
module traffic_quota_meter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [63:0]       i_tx_total,
    input  logic [63:0]       i_rx_total,
    input  logic [4:0]        i_day_of_month,
    input  logic [4:0]        i_days_in_month,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_throttle_active,
    output logic              o_throttle_started,
    output logic              o_throttle_ended,
    output logic              o_period_reset,
    output logic [63:0]       o_upload_used,
    output logic [63:0]       o_download_used,
    output logic [63:0]       o_total_used,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  tqm_pkg::t_cfg_idx i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    tqm_pkg::t_cfg    cfg;
    tqm_pkg::t_sample sample;
    logic             sample_valid;
    logic             core_load;

    // configuration registers
    tqm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register and deltas
    tqm_delta u_delta (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_tx_total      (i_tx_total),
        .i_rx_total      (i_rx_total),
        .i_day_of_month  (i_day_of_month),
        .i_days_in_month (i_days_in_month),
        .i_advance       (core_load),
        .o_valid         (sample_valid),
        .o_sample        (sample)
    );

    // quota update and result register
    tqm_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (sample_valid),
        .i_sample           (sample),
        .i_cfg              (cfg),
        .o_load             (core_load),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_throttle_active  (o_throttle_active),
        .o_throttle_started (o_throttle_started),
        .o_throttle_ended   (o_throttle_ended),
        .o_period_reset     (o_period_reset),
        .o_upload_used      (o_upload_used),
        .o_download_used    (o_download_used),
        .o_total_used       (o_total_used)
    );

`ifndef NO_ASSERTIONS
    // a throttle start always leaves throttling on
    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_throttle_started |-> o_throttle_active)
        else $error("throttle started but not active");

    // a lift without a new start leaves throttling off
    a_end_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_throttle_ended && !o_throttle_started |-> !o_throttle_active)
        else $error("throttle ended but still active");

    // an empty delta stage must take requests
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sample_valid |-> o_in_ready)
        else $error("input stalled with empty delta stage");

    // a free result register drains the delta stage
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_valid && (!o_out_valid || i_out_ready) |=> o_out_valid)
        else $error("request lost between stages");
`endif

endmodule
